// File: src/tcsr_pkg.sv
package tcsr_pkg;

    // default geometry
    localparam int DEF_TEXT_COLUMNS       = 100;
    localparam int DEF_TEXT_LINES         = 29;
    localparam int DEF_GLYPH_ROWS         = 16;
    localparam int DEF_SCREEN_PIXELS_WIDE = 800;
    localparam int DEF_SCREEN_LINES       = 480;
    localparam int DEF_BAR_HEIGHT         = 16;

    // stores
    localparam int FONT_DEPTH = 4096;
    localparam int FONT_AW    = 12;
    localparam int PAL_DEPTH  = 16;
    localparam int PAL_AW     = 4;
    localparam int PIX_W      = 16;
    localparam int CELL_PIX   = 8;

    // configuration port
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef logic [PIX_W-1:0] t_pixel;

    // item actions
    localparam logic [1:0] ACT_RENDER   = 2'd0;
    localparam logic [1:0] ACT_FONT_WR  = 2'd1;
    localparam logic [1:0] ACT_PAL_WR   = 2'd2;

    // register map, word index
    typedef enum logic [2:0] {
        REG_BAR_ENABLED     = 3'd0,
        REG_CURSOR_COLUMN   = 3'd1,
        REG_CURSOR_LINE     = 3'd2,
        REG_POINTER_X       = 3'd3,
        REG_POINTER_Y       = 3'd4,
        REG_POINTER_SHOWN   = 3'd5,
        REG_POINTER_BUSY    = 3'd6,
        REG_POINTER_PRESSED = 3'd7
    } t_reg_index;

    // register reset values
    localparam logic       RST_BAR_ENABLED   = 1'b1;
    localparam logic [7:0] RST_CURSOR_COLUMN = 8'hFF;
    localparam logic [5:0] RST_CURSOR_LINE   = 6'h3F;
    localparam logic [9:0] RST_POINTER_X     = 10'd400;
    localparam logic [8:0] RST_POINTER_Y     = 9'd240;

    // pointer colours
    localparam t_pixel FILL_NORMAL = 16'hFFFF;
    localparam t_pixel FILL_ALERT  = 16'hFFE0;
    localparam t_pixel EDGE_COLOUR = 16'h0000;
    localparam t_pixel BLACK       = 16'h0000;

    localparam int PTR_COLS = 12;
    localparam int PTR_ROWS = 18;

    localparam logic [PTR_COLS-1:0] ARROW_SHAPE [PTR_ROWS] = '{
        12'h800, 12'hC00, 12'hA00, 12'h900, 12'h880, 12'h840,
        12'h820, 12'h810, 12'h808, 12'h804, 12'h87C, 12'h890,
        12'hA10, 12'hC08, 12'h808, 12'h004, 12'h004, 12'h000
    };

    localparam logic [PTR_COLS-1:0] GLASS_SHAPE [PTR_ROWS] = '{
        12'hFFF, 12'h801, 12'h402, 12'h204, 12'h108, 12'h090,
        12'h060, 12'h060, 12'h090, 12'h108, 12'h204, 12'h402,
        12'h801, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000
    };

    // standard cga colours, palette contents after reset
    localparam t_pixel CGA_RESET [PAL_DEPTH] = '{
        16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hA520, 16'hAD55,
        16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF, 16'hFAAA, 16'hFABF, 16'hFFE0, 16'hFFFF
    };

    // one pointer mask row, zero outside the shape
    function automatic logic [PTR_COLS-1:0] ptr_row(input logic busy,
                                                     input logic signed [10:0] r);
        logic [4:0] idx;
        idx = r[4:0];
        if (r < 11'sd0 || r > 11'sd17) begin
            ptr_row = '0;
        end else if (busy) begin
            ptr_row = GLASS_SHAPE[idx];
        end else begin
            ptr_row = ARROW_SHAPE[idx];
        end
    endfunction

    // bit reversal so that index follows pixel offset
    function automatic logic [PTR_COLS-1:0] rev_row(input logic [PTR_COLS-1:0] v);
        logic [PTR_COLS-1:0] res;
        for (int b = 0; b < PTR_COLS; b++) begin
            res[b] = v[PTR_COLS-1-b];
        end
        rev_row = res;
    endfunction

endpackage

// File: src/tcsr_if.sv
// cell item channel
interface tcsr_cell_if import tcsr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  char_code;
    logic [7:0]  cell_attr;
    logic [6:0]  column;
    logic [8:0]  scanline;
    logic [11:0] table_address;
    logic [15:0] table_data;

    modport source (
        output valid, action, char_code, cell_attr, column, scanline,
               table_address, table_data,
        input  ready
    );

    modport sink (
        input  valid, action, char_code, cell_attr, column, scanline,
               table_address, table_data,
        output ready
    );
endinterface

// eight-pixel result channel
interface tcsr_pix_if import tcsr_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel_0;
    t_pixel pixel_1;
    t_pixel pixel_2;
    t_pixel pixel_3;
    t_pixel pixel_4;
    t_pixel pixel_5;
    t_pixel pixel_6;
    t_pixel pixel_7;

    modport source (
        output valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7,
        input  ready
    );

    modport sink (
        input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7,
        output ready
    );
endinterface

// File: src/tcsr_ram.sv
module tcsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port that holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/text_cell_scanline_renderer.sv
// Items pass through stage registers one to four, then the output register, where
// o_pix.valid rises for render items. Throughput: one cell per cycle while o_pix.ready
// allows; each stage and the output register moves on whenever the one after it is empty or moving on.
// The font read and palette reads are one registered RAM access in stage four.
// Reset: configuration registers load their reset values; frame counter, stage valid
// bits and palette valid bits clear, so unwritten palette entries read the cga colours.
module text_cell_scanline_renderer import tcsr_pkg::*; #(
    parameter int TEXT_COLUMNS       = DEF_TEXT_COLUMNS,
    parameter int TEXT_LINES         = DEF_TEXT_LINES,
    parameter int GLYPH_ROWS         = DEF_GLYPH_ROWS,
    parameter int SCREEN_PIXELS_WIDE = DEF_SCREEN_PIXELS_WIDE,
    parameter int SCREEN_LINES       = DEF_SCREEN_LINES,
    parameter int BAR_HEIGHT         = DEF_BAR_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcsr_cell_if.sink         i_cell,
    tcsr_pix_if.source        o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int TY_W   = 9;
    localparam int GROW_W = $clog2(GLYPH_ROWS);
    localparam int DIV_K  = 16;
    localparam int DIV_M  = (1 << DIV_K) / GLYPH_ROWS;
    localparam int PROD_W = DIV_K + TY_W;
    localparam int PTR_W  = PTR_COLS + 2;

    // configuration registers
    logic       r_bar_en;
    logic [7:0] r_cur_col;
    logic [5:0] r_cur_line;
    logic [9:0] r_ptr_x;
    logic [8:0] r_ptr_y;
    logic       r_ptr_shown;
    logic       r_ptr_busy;
    logic       r_ptr_pressed;

    logic [4:0]           r_frame;
    logic [PAL_DEPTH-1:0] r_pal_valid;

    // handshake and stage advance
    logic in_xfer;
    logic frame_start;
    logic adv1, adv2, adv3, adv4, adv_o;

    // stage 1
    logic             r_s1_valid;
    logic [1:0]       r_s1_action;
    logic [7:0]       r_s1_code;
    logic [7:0]       r_s1_attr;
    logic [6:0]       r_s1_col;
    logic [11:0]      r_s1_addr;
    logic [15:0]      r_s1_data;
    logic             r_s1_blink;
    logic             r_s1_y_ok;
    logic             r_s1_col_ok;
    logic [TY_W-1:0]  r_s1_ty;
    logic signed [9:0]  r_s1_dy;
    logic signed [11:0] r_s1_dx0;
    logic [9:0]       r_s1_x0;

    logic [4:0]         n_frame;
    logic               n_s1_blink;
    logic [TY_W-1:0]    n_bar;
    logic               n_s1_y_ok;
    logic               n_s1_col_ok;
    logic [TY_W-1:0]    n_s1_ty;
    logic signed [9:0]  n_s1_dy;
    logic [9:0]         n_s1_x0;
    logic signed [11:0] n_s1_dx0;

    // stage 2
    logic             r_s2_valid;
    logic [1:0]       r_s2_action;
    logic [7:0]       r_s2_code;
    logic [7:0]       r_s2_attr;
    logic [6:0]       r_s2_col;
    logic [11:0]      r_s2_addr;
    logic [15:0]      r_s2_data;
    logic             r_s2_blink;
    logic             r_s2_y_ok;
    logic             r_s2_col_ok;
    logic [TY_W-1:0]  r_s2_ty;
    logic [TY_W-1:0]  r_s2_q;
    logic signed [11:0] r_s2_dx0;
    logic [9:0]       r_s2_x0;
    logic [PTR_W-1:0] r_s2_ptr_c;
    logic [PTR_W-1:0] r_s2_ptr_h;

    logic [PROD_W-1:0]  n_s2_prod;
    logic [TY_W-1:0]    n_s2_q;
    logic [PTR_W-1:0]   n_s2_ptr_c;
    logic [PTR_W-1:0]   n_s2_ptr_h;
    logic signed [10:0] dy_ext;
    logic [PTR_COLS-1:0] row_up, row_mid, row_dn;
    logic [PTR_W-1:0]   ptr_e;
    logic               row_act;

    // stage 3
    logic               r_s3_valid;
    logic [1:0]         r_s3_action;
    logic [7:0]         r_s3_attr;
    logic [11:0]        r_s3_addr;
    logic [15:0]        r_s3_data;
    logic [FONT_AW-1:0] r_s3_faddr;
    logic               r_s3_text_ok;
    logic               r_s3_cur;
    logic [CELL_PIX-1:0] r_s3_fill;
    logic [CELL_PIX-1:0] r_s3_edge;

    logic [TY_W-1:0]     rem;
    logic [TY_W-1:0]     line;
    logic [GROW_W-1:0]   grow;
    logic                line_ok;
    logic                cur_row;
    logic [FONT_AW-1:0]  n_s3_faddr;
    logic                n_s3_text_ok;
    logic                n_s3_cur;
    logic [CELL_PIX-1:0] n_s3_fill;
    logic [CELL_PIX-1:0] n_s3_edge;

    // stage 4
    logic                r_s4_valid;
    logic [1:0]          r_s4_action;
    logic [3:0]          r_s4_fg_idx;
    logic [3:0]          r_s4_bg_idx;
    logic                r_s4_fg_valid;
    logic                r_s4_bg_valid;
    logic                r_s4_text_ok;
    logic                r_s4_cur;
    logic [CELL_PIX-1:0] r_s4_fill;
    logic [CELL_PIX-1:0] r_s4_edge;

    logic [7:0] font_q;
    t_pixel     fg_q;
    t_pixel     bg_q;
    logic       font_we;
    logic       pal_we;

    // output register
    logic   r_o_valid;
    t_pixel r_o_pix [CELL_PIX];
    t_pixel n_o_pix [CELL_PIX];
    t_pixel fg;
    t_pixel bg;
    t_pixel fill_col;

    //------------------------------------------------------------------
    // configuration port
    //------------------------------------------------------------------
    logic       cfg_wr;
    t_reg_index cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_index'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_en      <= RST_BAR_ENABLED;
            r_cur_col     <= RST_CURSOR_COLUMN;
            r_cur_line    <= RST_CURSOR_LINE;
            r_ptr_x       <= RST_POINTER_X;
            r_ptr_y       <= RST_POINTER_Y;
            r_ptr_shown   <= 1'b0;
            r_ptr_busy    <= 1'b0;
            r_ptr_pressed <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BAR_ENABLED:     r_bar_en      <= pwdata[0];
                REG_CURSOR_COLUMN:   r_cur_col     <= pwdata[7:0];
                REG_CURSOR_LINE:     r_cur_line    <= pwdata[5:0];
                REG_POINTER_X:       r_ptr_x       <= pwdata[9:0];
                REG_POINTER_Y:       r_ptr_y       <= pwdata[8:0];
                REG_POINTER_SHOWN:   r_ptr_shown   <= pwdata[0];
                REG_POINTER_BUSY:    r_ptr_busy    <= pwdata[0];
                REG_POINTER_PRESSED: r_ptr_pressed <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_BAR_ENABLED:     prdata = CFG_DW'(r_bar_en);
            REG_CURSOR_COLUMN:   prdata = CFG_DW'(r_cur_col);
            REG_CURSOR_LINE:     prdata = CFG_DW'(r_cur_line);
            REG_POINTER_X:       prdata = CFG_DW'(r_ptr_x);
            REG_POINTER_Y:       prdata = CFG_DW'(r_ptr_y);
            REG_POINTER_SHOWN:   prdata = CFG_DW'(r_ptr_shown);
            REG_POINTER_BUSY:    prdata = CFG_DW'(r_ptr_busy);
            REG_POINTER_PRESSED: prdata = CFG_DW'(r_ptr_pressed);
            default:             prdata = '0;
        endcase
    end

    //------------------------------------------------------------------
    // pipeline flow control
    //------------------------------------------------------------------
    assign adv_o = !r_o_valid || o_pix.ready;
    assign adv4  = !r_s4_valid || adv_o;
    assign adv3  = !r_s3_valid || adv4;
    assign adv2  = !r_s2_valid || adv3;
    assign adv1  = !r_s1_valid || adv2;

    assign i_cell.ready = adv1;
    assign in_xfer      = i_cell.valid && adv1;
    assign frame_start  = in_xfer && (i_cell.action == ACT_RENDER)
                          && (i_cell.scanline == 9'd0) && (i_cell.column == 7'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_frame    <= '0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_cell.valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (adv4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (adv_o) begin
                r_o_valid <= r_s4_valid && (r_s4_action == ACT_RENDER);
            end
            if (frame_start) begin
                r_frame <= n_frame;
            end
        end
    end

    //------------------------------------------------------------------
    // stage 1: frame count, vertical position, pointer offsets
    //------------------------------------------------------------------
    always_comb begin
        n_frame     = r_frame + 5'd1;
        n_s1_blink  = frame_start ? n_frame[4] : r_frame[4];
        n_bar       = r_bar_en ? TY_W'(BAR_HEIGHT) : '0;
        n_s1_y_ok   = ({3'b000, i_cell.scanline} < 12'(SCREEN_LINES))
                      && (i_cell.scanline >= n_bar);
        n_s1_col_ok = ({2'b00, i_cell.column} < 9'(TEXT_COLUMNS));
        n_s1_ty     = i_cell.scanline - n_bar;
        n_s1_dy     = $signed({1'b0, i_cell.scanline}) - $signed({1'b0, r_ptr_y});
        n_s1_x0     = {i_cell.column, 3'b000};
        n_s1_dx0    = $signed({2'b00, n_s1_x0}) - $signed({2'b00, r_ptr_x});
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_action <= i_cell.action;
            r_s1_code   <= i_cell.char_code;
            r_s1_attr   <= i_cell.cell_attr;
            r_s1_col    <= i_cell.column;
            r_s1_addr   <= i_cell.table_address;
            r_s1_data   <= i_cell.table_data;
            r_s1_blink  <= n_s1_blink;
            r_s1_y_ok   <= n_s1_y_ok;
            r_s1_col_ok <= n_s1_col_ok;
            r_s1_ty     <= n_s1_ty;
            r_s1_dy     <= n_s1_dy;
            r_s1_x0     <= n_s1_x0;
            r_s1_dx0    <= n_s1_dx0;
        end
    end

    //------------------------------------------------------------------
    // stage 2: reciprocal multiply for the text line, pointer mask rows
    //------------------------------------------------------------------
    always_comb begin
        n_s2_prod = PROD_W'(r_s1_ty) * PROD_W'(DIV_M);
        n_s2_q    = n_s2_prod[DIV_K +: TY_W];

        dy_ext  = {r_s1_dy[9], r_s1_dy};
        row_act = r_ptr_shown && (r_s1_dy >= -10'sd1) && (r_s1_dy <= 10'sd18);
        row_up  = ptr_row(r_ptr_busy, dy_ext - 11'sd1);
        row_mid = ptr_row(r_ptr_busy, dy_ext);
        row_dn  = ptr_row(r_ptr_busy, dy_ext + 11'sd1);

        // index k of these rows is pixel offset k-1 from the hot spot
        ptr_e      = {1'b0, rev_row(row_up | row_mid | row_dn), 1'b0};
        n_s2_ptr_c = {1'b0, rev_row(row_mid), 1'b0};
        n_s2_ptr_h = ptr_e | (ptr_e << 1) | (ptr_e >> 1);
        if (!row_act) begin
            n_s2_ptr_c = '0;
            n_s2_ptr_h = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_action <= r_s1_action;
            r_s2_code   <= r_s1_code;
            r_s2_attr   <= r_s1_attr;
            r_s2_col    <= r_s1_col;
            r_s2_addr   <= r_s1_addr;
            r_s2_data   <= r_s1_data;
            r_s2_blink  <= r_s1_blink;
            r_s2_y_ok   <= r_s1_y_ok;
            r_s2_col_ok <= r_s1_col_ok;
            r_s2_ty     <= r_s1_ty;
            r_s2_q      <= n_s2_q;
            r_s2_x0     <= r_s1_x0;
            r_s2_dx0    <= r_s1_dx0;
            r_s2_ptr_c  <= n_s2_ptr_c;
            r_s2_ptr_h  <= n_s2_ptr_h;
        end
    end

    //------------------------------------------------------------------
    // stage 3: quotient correction, font address, cursor, pointer pixels
    //------------------------------------------------------------------
    always_comb begin
        logic signed [11:0] d;
        logic [3:0]         k;
        logic               x_ok;
        logic               in_rng;

        // estimate is exact or one low
        rem = r_s2_ty - TY_W'(r_s2_q * TY_W'(GLYPH_ROWS));
        if (rem >= TY_W'(GLYPH_ROWS)) begin
            line = r_s2_q + TY_W'(1);
            grow = GROW_W'(rem - TY_W'(GLYPH_ROWS));
        end else begin
            line = r_s2_q;
            grow = GROW_W'(rem);
        end

        line_ok      = line < TY_W'(TEXT_LINES);
        n_s3_text_ok = r_s2_y_ok && r_s2_col_ok && line_ok;
        n_s3_faddr   = FONT_AW'(FONT_AW'(r_s2_code) * FONT_AW'(GLYPH_ROWS))
                       + FONT_AW'(grow);

        // cursor covers the last two glyph rows of its cell while blink is on
        cur_row  = ({1'b0, grow} + (GROW_W+1)'(2)) >= (GROW_W+1)'(GLYPH_ROWS);
        n_s3_cur = !r_cur_line[5] && (TY_W'(r_cur_line[4:0]) == line)
                   && !r_cur_col[7] && (r_cur_col[6:0] == r_s2_col)
                   && cur_row && r_s2_blink;

        // pointer fill and outline per pixel
        for (int i = 0; i < CELL_PIX; i++) begin
            d      = r_s2_dx0 + $signed(12'(i));
            x_ok   = ({2'b00, r_s2_x0} + 12'(i)) < 12'(SCREEN_PIXELS_WIDE);
            in_rng = (d >= -12'sd1) && (d <= 12'sd12);
            k      = 4'(d + 12'sd1);
            n_s3_fill[i] = x_ok && in_rng && r_s2_ptr_c[k];
            n_s3_edge[i] = x_ok && in_rng && !r_s2_ptr_c[k] && r_s2_ptr_h[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_action  <= r_s2_action;
            r_s3_attr    <= r_s2_attr;
            r_s3_addr    <= r_s2_addr;
            r_s3_data    <= r_s2_data;
            r_s3_faddr   <= n_s3_faddr;
            r_s3_text_ok <= n_s3_text_ok;
            r_s3_cur     <= n_s3_cur;
            r_s3_fill    <= n_s3_fill;
            r_s3_edge    <= n_s3_edge;
        end
    end

    //------------------------------------------------------------------
    // stage 4: font and palette access, table writes in item order
    //------------------------------------------------------------------
    assign font_we = r_s3_valid && adv4 && (r_s3_action == ACT_FONT_WR);
    assign pal_we  = r_s3_valid && adv4 && (r_s3_action == ACT_PAL_WR)
                     && (r_s3_addr[11:PAL_AW] == '0);

    tcsr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (r_s3_addr),
        .i_wdata (r_s3_data[7:0]),
        .i_re    (adv4),
        .i_raddr (r_s3_faddr),
        .o_rdata (font_q)
    );

    tcsr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_fg_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_s3_addr[PAL_AW-1:0]),
        .i_wdata (r_s3_data),
        .i_re    (adv4),
        .i_raddr (r_s3_attr[3:0]),
        .o_rdata (fg_q)
    );

    tcsr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PAL_DEPTH)
    ) u_pal_bg_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (r_s3_addr[PAL_AW-1:0]),
        .i_wdata (r_s3_data),
        .i_re    (adv4),
        .i_raddr (r_s3_attr[7:4]),
        .o_rdata (bg_q)
    );

    // palette entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_valid <= '0;
        end else if (pal_we) begin
            r_pal_valid[r_s3_addr[PAL_AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_s4_action   <= r_s3_action;
            r_s4_fg_idx   <= r_s3_attr[3:0];
            r_s4_bg_idx   <= r_s3_attr[7:4];
            r_s4_fg_valid <= r_pal_valid[r_s3_attr[3:0]];
            r_s4_bg_valid <= r_pal_valid[r_s3_attr[7:4]];
            r_s4_text_ok  <= r_s3_text_ok;
            r_s4_cur      <= r_s3_cur;
            r_s4_fill     <= r_s3_fill;
            r_s4_edge     <= r_s3_edge;
        end
    end

    //------------------------------------------------------------------
    // output: colour select and pointer blend
    //------------------------------------------------------------------
    always_comb begin
        fg       = r_s4_fg_valid ? fg_q : CGA_RESET[r_s4_fg_idx];
        bg       = r_s4_bg_valid ? bg_q : CGA_RESET[r_s4_bg_idx];
        fill_col = (r_ptr_busy || r_ptr_pressed) ? FILL_ALERT : FILL_NORMAL;
        for (int i = 0; i < CELL_PIX; i++) begin
            if (!r_s4_text_ok) begin
                n_o_pix[i] = BLACK;
            end else if (r_s4_cur || font_q[CELL_PIX-1-i]) begin
                n_o_pix[i] = fg;
            end else begin
                n_o_pix[i] = bg;
            end
            if (r_s4_fill[i]) begin
                n_o_pix[i] = fill_col;
            end else if (r_s4_edge[i]) begin
                n_o_pix[i] = EDGE_COLOUR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o) begin
            r_o_pix <= n_o_pix;
        end
    end

    assign o_pix.valid   = r_o_valid;
    assign o_pix.pixel_0 = r_o_pix[0];
    assign o_pix.pixel_1 = r_o_pix[1];
    assign o_pix.pixel_2 = r_o_pix[2];
    assign o_pix.pixel_3 = r_o_pix[3];
    assign o_pix.pixel_4 = r_o_pix[4];
    assign o_pix.pixel_5 = r_o_pix[5];
    assign o_pix.pixel_6 = r_o_pix[6];
    assign o_pix.pixel_7 = r_o_pix[7];

`ifndef ASSERT_OFF
    // table writes never produce a result
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_valid && (r_s4_action != ACT_RENDER) && adv_o |=> !r_o_valid)
        else $error("table write produced a result");

    // a new result only comes from a render item in stage four
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_o_valid && !$past(r_o_valid)
        |-> $past(r_s4_valid) && ($past(r_s4_action) == ACT_RENDER))
        else $error("result without render item");

    // frame counter moves only on a frame-start transfer
    a_frame_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(frame_start) |-> r_frame == $past(r_frame))
        else $error("frame counter moved without frame start");

    // palette valid bits are never cleared outside reset
    a_pal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_pal_valid & $past(r_pal_valid)) == $past(r_pal_valid))
        else $error("palette valid bit cleared");
`endif

endmodule

// File: tb/sv/text_cell_scanline_renderer_test.sv
module text_cell_scanline_renderer_test import tcsr_pkg::*; ();

    // screen geometry of the default build
    localparam int NUM_COLUMNS = 100;
    localparam int NUM_LINES   = 29;
    localparam int GLYPH_H     = 16;
    localparam int SCREEN_W    = 800;
    localparam int SCREEN_H    = 480;
    localparam int BAR_LINES   = 16;

    // run control
    localparam int SETTLE_CYCLES   = 8;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int PHASE_ITEMS     = 75;
    localparam int PHASES          = 6;
    localparam int IDLE_PCT        = 35;

    // action code with no effect
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    // config pick modes
    localparam int PICK_LOW  = 0;
    localparam int PICK_HIGH = 1;
    localparam int PICK_RAND = 2;

    // pointer colors
    localparam t_pixel FILL_WHITE  = 16'hFFFF;
    localparam t_pixel FILL_YELLOW = 16'hFFE0;
    localparam t_pixel OUTLINE_PIX = 16'h0000;

    localparam logic [11:0] ARROW_ROWS [18] = '{
        12'h800, 12'hC00, 12'hA00, 12'h900, 12'h880, 12'h840,
        12'h820, 12'h810, 12'h808, 12'h804, 12'h87C, 12'h890,
        12'hA10, 12'hC08, 12'h808, 12'h004, 12'h004, 12'h000
    };

    localparam logic [11:0] GLASS_ROWS [18] = '{
        12'hFFF, 12'h801, 12'h402, 12'h204, 12'h108, 12'h090,
        12'h060, 12'h060, 12'h090, 12'h108, 12'h204, 12'h402,
        12'h801, 12'hFFF, 12'h000, 12'h000, 12'h000, 12'h000
    };

    localparam t_pixel CGA_COLORS [16] = '{
        16'h0000, 16'h0015, 16'h0540, 16'h0555, 16'hA800, 16'hA815, 16'hA520, 16'hAD55,
        16'h52AA, 16'h52BF, 16'h57EA, 16'h57FF, 16'hFAAA, 16'hFABF, 16'hFFE0, 16'hFFFF
    };

    typedef logic [CELL_PIX-1:0][PIX_W-1:0] t_cell_px;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  code;
        logic [7:0]  attr;
        logic [6:0]  column;
        logic [8:0]  scanline;
        logic [11:0] addr;
        logic [15:0] data;
    } t_cell_item;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    tcsr_cell_if cell_bus ();
    tcsr_pix_if  pix_bus ();

    text_cell_scanline_renderer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_bus),
        .o_pix   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the renderer state
    logic [7:0] font_mem [FONT_DEPTH];
    bit         font_loaded [FONT_DEPTH];
    t_pixel     palette [PAL_DEPTH];
    logic [4:0] frame_ctr;
    int         bar_on;
    int         cur_column;
    int         cur_line;
    int         ptr_x;
    int         ptr_y;
    int         ptr_on;
    int         ptr_busy;
    int         ptr_pressed;

    t_cell_px pending_pixels [$];
    int       mismatches   = 0;
    int       src_idle_pct = IDLE_PCT;
    int       snk_idle_pct = IDLE_PCT;
    bit       hold_req     = 1'b0;
    int       hold_left    = 0;
    int       quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // pointer mask lookup, zero outside the 12x18 box
    function automatic bit mask_bit(input int dx, input int dy);
        logic [11:0] row;
        if (dx < 0 || dx >= 12 || dy < 0 || dy >= 18) return 1'b0;
        row = ptr_busy ? GLASS_ROWS[dy] : ARROW_ROWS[dy];
        return row[11-dx];
    endfunction

    // pointer fill and one-pixel black outline over the cell
    function automatic t_cell_px blend_pointer(input t_cell_px px, input int x0, input int y);
        t_cell_px res;
        t_pixel   fill;
        int       dx;
        int       dy;
        bit       outline;
        res = px;
        dy  = y - ptr_y;
        if (ptr_on == 0 || dy < -1 || dy > 18) return res;
        fill = (ptr_busy != 0 || ptr_pressed != 0) ? FILL_YELLOW : FILL_WHITE;
        for (int i = 0; i < CELL_PIX; i++) begin
            dx = x0 + i - ptr_x;
            if (x0 + i < SCREEN_W && dx >= -1 && dx <= 12) begin
                if (mask_bit(dx, dy)) begin
                    res[i] = fill;
                end else begin
                    outline = 1'b0;
                    for (int oy = -1; oy <= 1; oy++)
                        for (int ox = -1; ox <= 1; ox++)
                            if (mask_bit(dx + ox, dy + oy)) outline = 1'b1;
                    if (outline) res[i] = OUTLINE_PIX;
                end
            end
        end
        return res;
    endfunction

    // font address a render reads, or -1 outside the text area
    function automatic int glyph_address(input t_cell_item it);
        int ty;
        ty = int'(it.scanline) - (bar_on != 0 ? BAR_LINES : 0);
        if (it.action != ACT_RENDER || int'(it.scanline) >= SCREEN_H || ty < 0 ||
            int'(it.column) >= NUM_COLUMNS || ty / GLYPH_H >= NUM_LINES) return -1;
        return (int'(it.code) * GLYPH_H + ty % GLYPH_H) % FONT_DEPTH;
    endfunction

    // apply one cell item to the shadow state, returns 1 with the pixels of a render
    function automatic bit paint_cell(input t_cell_item it, output t_cell_px px);
        int         fa;
        int         ty;
        int         line_idx;
        int         grow;
        t_pixel     fg;
        t_pixel     bg;
        logic [7:0] bits;
        bit         cur;
        px = '0;
        if (it.action == ACT_FONT_WR) begin
            font_mem[it.addr]    = it.data[7:0];
            font_loaded[it.addr] = 1'b1;
            return 1'b0;
        end
        if (it.action == ACT_PAL_WR) begin
            if (int'(it.addr) < PAL_DEPTH) palette[it.addr[3:0]] = it.data;
            return 1'b0;
        end
        if (it.action != ACT_RENDER) return 1'b0;
        // frame start advances the blink counter first
        if (it.scanline == 9'd0 && it.column == 7'd0) frame_ctr = frame_ctr + 5'd1;
        fa = glyph_address(it);
        if (fa >= 0) begin
            ty       = int'(it.scanline) - (bar_on != 0 ? BAR_LINES : 0);
            line_idx = ty / GLYPH_H;
            grow     = ty % GLYPH_H;
            fg       = palette[it.attr[3:0]];
            bg       = palette[it.attr[7:4]];
            bits     = font_mem[fa];
            cur      = frame_ctr[4] && cur_line == line_idx &&
                       cur_column == int'(it.column) && grow >= GLYPH_H - 2;
            for (int i = 0; i < CELL_PIX; i++) px[i] = (cur || bits[7-i]) ? fg : bg;
        end
        px = blend_pointer(px, int'(it.column) * CELL_PIX, int'(it.scanline));
        return 1'b1;
    endfunction

    function automatic t_cell_item random_item();
        t_cell_item it;
        it.action   = 2'($urandom);
        it.code     = 8'($urandom);
        it.attr     = 8'($urandom);
        it.column   = 7'($urandom);
        it.scanline = 9'($urandom);
        it.addr     = 12'($urandom);
        it.data     = 16'($urandom);
        return it;
    endfunction

    function automatic t_cell_item render_at(input int col, input int y,
                                             input logic [7:0] code, input logic [7:0] attr);
        t_cell_item it;
        it          = random_item();
        it.action   = ACT_RENDER;
        it.column   = 7'(col);
        it.scanline = 9'(y);
        it.code     = code;
        it.attr     = attr;
        return it;
    endfunction

    function automatic t_cell_item table_item(input logic [1:0] action, input int addr,
                                              input int data);
        t_cell_item it;
        it        = random_item();
        it.action = action;
        it.addr   = 12'(addr);
        it.data   = 16'(data);
        return it;
    endfunction

    // random mix, renders aimed at frame starts, the cursor and the pointer
    function automatic t_cell_item random_traffic_item();
        t_cell_item it;
        int         r;
        int         s;
        int         c;
        int         y;
        it = random_item();
        r  = $urandom_range(99);
        if (r < 8) begin
            it.action = ACT_FONT_WR;
        end else if (r < 14) begin
            it.action = ACT_PAL_WR;
            if ($urandom_range(3) != 0) it.addr = 12'($urandom_range(PAL_DEPTH - 1));
        end else if (r < 17) begin
            it.action = ACT_IGNORED;
        end else begin
            it.action = ACT_RENDER;
            s = $urandom_range(99);
            c = $urandom_range(NUM_COLUMNS - 1);
            y = $urandom_range(SCREEN_H - 1);
            if ($urandom_range(9) == 0) c = $urandom_range(127);
            if ($urandom_range(9) == 0) y = $urandom_range(511);
            if (s < 10) begin
                c = 0;
                y = 0;
            end else if (s < 35) begin
                if (cur_column >= 0) c = cur_column;
                if (cur_line >= 0) y = (bar_on != 0 ? BAR_LINES : 0) +
                    cur_line * GLYPH_H + $urandom_range(GLYPH_H - 1, GLYPH_H - 4);
            end else if (s < 60) begin
                y = ptr_y + int'($urandom_range(21)) - 2;
                c = (ptr_x + int'($urandom_range(23)) - 9);
                c = (c < 0 ? 0 : c) / CELL_PIX;
                y = (y < 0) ? 0 : (y > 511 ? 511 : y);
            end
            it.column   = 7'(c);
            it.scanline = 9'(y);
        end
        return it;
    endfunction

    function automatic int pick(input int mode, input int lo, input int hi);
        int r;
        r = $urandom_range(9);
        if (mode == PICK_LOW || (mode == PICK_RAND && r < 2)) return lo;
        if (mode == PICK_HIGH || (mode == PICK_RAND && r < 4)) return hi;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // one cell transfer, with random idle cycles ahead of it
    task automatic transfer_cell(input t_cell_item it);
        t_cell_px px;
        while ($urandom_range(99) < src_idle_pct) begin
            cell_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_bus.valid         <= 1'b1;
        cell_bus.action        <= it.action;
        cell_bus.char_code     <= it.code;
        cell_bus.cell_attr     <= it.attr;
        cell_bus.column        <= it.column;
        cell_bus.scanline      <= it.scanline;
        cell_bus.table_address <= it.addr;
        cell_bus.table_data    <= it.data;
        @(posedge i_clk);
        while (!cell_bus.ready) @(posedge i_clk);
        if (paint_cell(it, px)) pending_pixels.push_back(px);
    endtask

    // load the glyph row a render reads before the render itself
    task automatic send_item(input t_cell_item it);
        int fa;
        fa = glyph_address(it);
        if (fa >= 0 && !font_loaded[fa]) transfer_cell(table_item(ACT_FONT_WR, fa, $urandom));
        transfer_cell(it);
    endtask

    task automatic drain_pixels();
        cell_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write, setup then access phase
    task automatic write_reg(input t_reg_index idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_BAR_ENABLED:     bar_on      = value & 1;
            REG_CURSOR_COLUMN:   cur_column  = $signed(value[7:0]);
            REG_CURSOR_LINE:     cur_line    = $signed(value[5:0]);
            REG_POINTER_X:       ptr_x       = value & 32'h3FF;
            REG_POINTER_Y:       ptr_y       = value & 32'h1FF;
            REG_POINTER_SHOWN:   ptr_on      = value & 1;
            REG_POINTER_BUSY:    ptr_busy    = value & 1;
            REG_POINTER_PRESSED: ptr_pressed = value & 1;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_config(input int mode);
        write_reg(REG_BAR_ENABLED, pick(mode, 0, 1));
        write_reg(REG_CURSOR_COLUMN, pick(mode, -1, NUM_COLUMNS - 1));
        write_reg(REG_CURSOR_LINE, pick(mode, -1, NUM_LINES - 1));
        write_reg(REG_POINTER_X, pick(mode, 0, SCREEN_W - 1));
        write_reg(REG_POINTER_Y, pick(mode, 0, SCREEN_H - 1));
        write_reg(REG_POINTER_SHOWN, mode == PICK_RAND ? int'($urandom_range(3) != 0)
                                                       : pick(mode, 0, 1));
        write_reg(REG_POINTER_BUSY, pick(mode, 0, 1));
        write_reg(REG_POINTER_PRESSED, pick(mode, 0, 1));
    endtask

    task automatic run_traffic(input int count);
        for (int n = 0; n < count; n++) send_item(random_traffic_item());
    endtask

    // reset palette and registers: bar on, cursor and pointer hidden
    task automatic test_reset_state();
        send_item(render_at(0, 0, 8'hFF, 8'hFF));
        send_item(render_at(0, BAR_LINES, 8'h00, 8'hF0));
        send_item(render_at(NUM_COLUMNS - 1, SCREEN_H - 1, 8'hFF, 8'h0F));
        send_item(render_at(50, SCREEN_H, 8'h5A, 8'h12));
        send_item(render_at(127, 511, 8'hA5, 8'h34));
        send_item(render_at(NUM_COLUMNS, 100, 8'h3C, 8'h56));
    endtask

    // font and palette loads, out-of-range palette index, unknown action
    task automatic test_table_writes();
        send_item(table_item(ACT_FONT_WR, FONT_DEPTH - 1, 16'hFF5A));
        send_item(table_item(ACT_PAL_WR, 0, 16'hFFFF));
        send_item(table_item(ACT_PAL_WR, PAL_DEPTH - 1, 16'h0000));
        send_item(table_item(ACT_PAL_WR, PAL_DEPTH, 16'h1234));
        send_item(table_item(ACT_PAL_WR, FONT_DEPTH - 1, 16'h5555));
        send_item(table_item(ACT_IGNORED, FONT_DEPTH - 1, 16'hFFFF));
        send_item(render_at(0, BAR_LINES + GLYPH_H - 1, 8'hFF, 8'h0F));
    endtask

    // text from scanline zero, last text row and the row past it
    task automatic test_bar_off();
        drain_pixels();
        write_reg(REG_BAR_ENABLED, 0);
        send_item(render_at(0, 0, 8'h81, 8'h1E));
        send_item(render_at(NUM_COLUMNS - 1, NUM_LINES * GLYPH_H - 1, 8'h42, 8'hE1));
        send_item(render_at(10, NUM_LINES * GLYPH_H, 8'h24, 8'h77));
    endtask

    // arrow at the top left, pressed arrow at the bottom right, hourglass mid screen
    task automatic test_pointer();
        drain_pixels();
        write_reg(REG_POINTER_SHOWN, 1);
        write_reg(REG_POINTER_X, 0);
        write_reg(REG_POINTER_Y, 0);
        send_item(render_at(0, 1, 8'h10, 8'h21));
        send_item(render_at(1, 10, 8'h11, 8'h32));
        send_item(render_at(0, 18, 8'h12, 8'h43));
        drain_pixels();
        write_reg(REG_POINTER_PRESSED, 1);
        write_reg(REG_POINTER_X, SCREEN_W - 1);
        write_reg(REG_POINTER_Y, SCREEN_H - 1);
        write_reg(REG_BAR_ENABLED, 1);
        send_item(render_at(NUM_COLUMNS - 1, SCREEN_H - 1, 8'h13, 8'h54));
        send_item(render_at(NUM_COLUMNS, SCREEN_H - 1, 8'h14, 8'h65));
        drain_pixels();
        write_reg(REG_POINTER_BUSY, 1);
        write_reg(REG_POINTER_X, 400);
        write_reg(REG_POINTER_Y, 240);
        send_item(render_at(50, 240, 8'h15, 8'h76));
        send_item(render_at(51, 245, 8'h16, 8'h87));
        send_item(render_at(49, 253, 8'h17, 8'h98));
    endtask

    // cursor rows with blink still off
    task automatic test_cursor();
        drain_pixels();
        write_reg(REG_POINTER_SHOWN, 0);
        write_reg(REG_CURSOR_COLUMN, 5);
        write_reg(REG_CURSOR_LINE, 2);
        send_item(render_at(5, BAR_LINES + 2 * GLYPH_H + GLYPH_H - 2, 8'h20, 8'h4A));
        send_item(render_at(5, BAR_LINES + 3 * GLYPH_H - 1, 8'h21, 8'h5B));
    endtask

    // random phases across low, high and random register settings
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_pixels();
            program_config(phase < 2 ? phase : PICK_RAND);
            if (phase == 4) begin
                run_traffic(PHASE_ITEMS / 2);
                drain_pixels();
                run_traffic(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                run_traffic(PHASE_ITEMS);
            end
        end
    endtask

    // back-to-back transfers on both sides
    task automatic test_no_idle();
        drain_pixels();
        program_config(PICK_RAND);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_traffic(100);
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;
    endtask

    // receiver holds off while the sender keeps offering cells
    task automatic test_backpressure();
        drain_pixels();
        program_config(PICK_RAND);
        src_idle_pct = 0;
        hold_req     = 1'b1;
        run_traffic(60);
        src_idle_pct = IDLE_PCT;
    endtask

    // pixel receiver with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pix_bus.ready <= 1'b0;
        end else begin
            pix_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic void check_pixel(input int idx, input t_pixel want, input t_pixel got);
        if (got !== want) begin
            $error("pixel_%0d: expected %h, got %h", idx, want, got);
            mismatches++;
        end
    endfunction

    // compare each pixel transfer with the oldest pending cell
    always @(posedge i_clk) begin
        t_cell_px want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel transfer with no cell pending");
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                check_pixel(0, want[0], pix_bus.pixel_0);
                check_pixel(1, want[1], pix_bus.pixel_1);
                check_pixel(2, want[2], pix_bus.pixel_2);
                check_pixel(3, want[3], pix_bus.pixel_3);
                check_pixel(4, want[4], pix_bus.pixel_4);
                check_pixel(5, want[5], pix_bus.pixel_5);
                check_pixel(6, want[6], pix_bus.pixel_6);
                check_pixel(7, want[7], pix_bus.pixel_7);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((cell_bus.valid && cell_bus.ready) || (pix_bus.valid && pix_bus.ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cell_bus.valid         = 1'b0;
        cell_bus.action        = ACT_RENDER;
        cell_bus.char_code     = '0;
        cell_bus.cell_attr     = '0;
        cell_bus.column        = '0;
        cell_bus.scanline      = '0;
        cell_bus.table_address = '0;
        cell_bus.table_data    = '0;
        pix_bus.ready          = 1'b0;
        // shadow state after reset
        for (int i = 0; i < PAL_DEPTH; i++) palette[i] = CGA_COLORS[i];
        frame_ctr   = '0;
        bar_on      = 1;
        cur_column  = -1;
        cur_line    = -1;
        ptr_x       = 400;
        ptr_y       = 240;
        ptr_on      = 0;
        ptr_busy    = 0;
        ptr_pressed = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_table_writes();
        test_bar_off();
        test_pointer();
        test_cursor();
        test_random_traffic();
        test_no_idle();
        test_backpressure();
        drain_pixels();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
